>>> hdl/srbe_pkg.sv
package srbe_pkg;

    localparam int WORD_BITS    = 32;
    localparam int BIT_W        = $clog2(WORD_BITS);
    // every zone holds the same number of granules, so the granule index width is fixed
    localparam int GRAN_IDX_W   = 16;
    localparam int WORD_IDX_W   = GRAN_IDX_W - BIT_W;
    localparam int BITMAP_WORDS = 1 << WORD_IDX_W;

    localparam int ADDR_W   = 35;
    localparam int SIZE_W   = 32;
    localparam int RADDR_W  = ADDR_W + 1;
    localparam int SUM_W    = ADDR_W + 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 35;

    localparam int GRAN_SHIFT_BASE = 16;
    localparam int ZONE_SHIFT_BASE = 32;
    localparam logic [RADDR_W-1:0] REMAP_BASE_ADDR = 36'h0_E000_0000;

    localparam logic [1:0] REQ_SET   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_CHECK = 2'd2;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_WIN1 = 2'd1;
    localparam logic [1:0] MODE_WIN2 = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_MISALIGNED = 3'd1;
    localparam logic [2:0] ST_RANGE      = 3'd2;
    localparam logic [2:0] ST_CHECK_FAIL = 3'd3;
    localparam logic [2:0] ST_BAD_TYPE   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_SELECT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN1_START   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN1_END     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN2_START   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN2_END     = 3'd5;

    typedef struct packed {
        logic load;
        logic clr;
        logic remap;
        logic setup;
        logic rd;
        logic modify;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic misaligned;
        logic range_err;
        logic bad_type;
        logic check_fail;
        logic last_word;
    } sts_t;

endpackage

>>> hdl/secure_region_bitmap_engine_core.sv
// channel    | handshake              | payload
// -----------+------------------------+-------------------------------------
// request    | start & !busy          | req_type, req_addr, region_size
// result     | done (one-cycle pulse) | status
// config     | cfg_wr_en              | cfg_index, cfg_wdata
//
// a rejected request ends in the setup state; one that walks the bitmap passes
// through a read and a write-back state per word (a check does not write back)
// on the single bitmap memory port
// after reset a clearing pass zeroes the 2048 bitmap words, one per cycle, with
// busy high; configuration writes are taken throughout
// the result strobe cannot be stalled, and busy drops in the cycle it shows
module secure_region_bitmap_engine_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        req_type,
    input  logic [srbe_pkg::ADDR_W-1:0]       req_addr,
    input  logic [srbe_pkg::SIZE_W-1:0]       region_size,
    output logic                              done,
    output logic [2:0]                        status,
    input  logic                              cfg_wr_en,
    input  logic [srbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srbe_pkg::CFG_W-1:0]        cfg_wdata
);

    srbe_pkg::cmd_t cmd;
    srbe_pkg::sts_t sts;

    srbe_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .status (status),
        .cmd    (cmd),
        .sts    (sts)
    );

    srbe_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .req_type    (req_type),
        .req_addr    (req_addr),
        .region_size (region_size),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

>>> hdl/srbe_datapath.sv
module srbe_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [srbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srbe_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic [1:0]                        req_type,
    input  logic [srbe_pkg::ADDR_W-1:0]       req_addr,
    input  logic [srbe_pkg::SIZE_W-1:0]       region_size,
    input  srbe_pkg::cmd_t                    cmd,
    output srbe_pkg::sts_t                    sts
);

    localparam int WB  = srbe_pkg::WORD_BITS;
    localparam int BW  = srbe_pkg::BIT_W;
    localparam int GW  = srbe_pkg::GRAN_IDX_W;
    localparam int WW  = srbe_pkg::WORD_IDX_W;
    localparam int AW  = srbe_pkg::ADDR_W;
    localparam int RW  = srbe_pkg::RADDR_W;
    localparam int SW  = srbe_pkg::SIZE_W;
    localparam int XW  = srbe_pkg::SUM_W;
    localparam int EW  = GW + 1;

    // configuration registers
    logic [1:0]    zone_reg, zone_next;
    logic [1:0]    mode_reg, mode_next;
    logic [AW-1:0] w1s_reg, w1s_next;
    logic [AW-1:0] w1e_reg, w1e_next;
    logic [AW-1:0] w2s_reg, w2s_next;
    logic [AW-1:0] w2e_reg, w2e_next;

    // request and walk state
    logic [1:0]    type_reg, type_next;
    logic [RW-1:0] addr_reg, addr_next;
    logic [SW-1:0] size_reg, size_next;
    logic [WW-1:0] word_reg, word_next;
    logic [BW-1:0] bit_reg, bit_next;
    logic [GW-1:0] count_reg, count_next;
    logic [WW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [WB-1:0] rd_data_reg;

    logic [WB-1:0] bitmap_mem [srbe_pkg::BITMAP_WORDS];

    logic [5:0]    gran_shift;
    logic [SW-1:0] gran_mask;
    logic [XW-1:0] zone_size;
    logic [XW-1:0] end_addr;
    logic [RW-1:0] shifted_addr;
    logic [SW-1:0] shifted_size;
    logic          in_win1, in_win2;
    logic [EW-1:0] end_pos;
    logic          full_word;
    logic [WB-1:0] lo_mask, hi_mask, bit_mask, wr_data;
    logic          check_only;

    always_comb
    begin
        zone_next = zone_reg;
        mode_next = mode_reg;
        w1s_next  = w1s_reg;
        w1e_next  = w1e_reg;
        w2s_next  = w2s_reg;
        w2e_next  = w2e_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                srbe_pkg::CFG_ZONE_SELECT: zone_next = cfg_wdata[1:0];
                srbe_pkg::CFG_SHIFT_MODE:  mode_next = cfg_wdata[1:0];
                srbe_pkg::CFG_WIN1_START:  w1s_next  = cfg_wdata[AW-1:0];
                srbe_pkg::CFG_WIN1_END:    w1e_next  = cfg_wdata[AW-1:0];
                srbe_pkg::CFG_WIN2_START:  w2s_next  = cfg_wdata[AW-1:0];
                srbe_pkg::CFG_WIN2_END:    w2e_next  = cfg_wdata[AW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg    <= '0;
            mode_reg    <= '0;
            w1s_reg     <= '0;
            w1e_reg     <= '0;
            w2s_reg     <= '0;
            w2e_reg     <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            zone_reg    <= zone_next;
            mode_reg    <= mode_next;
            w1s_reg     <= w1s_next;
            w1e_reg     <= w1e_next;
            w2s_reg     <= w2s_next;
            w2e_reg     <= w2e_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign clr_cnt_next = cmd.clr ? clr_cnt_reg + WW'(1) : clr_cnt_reg;

    // granule and zone follow the zone selection
    assign gran_shift = 6'(srbe_pkg::GRAN_SHIFT_BASE) + {4'd0, zone_reg};
    assign gran_mask  = ~({SW{1'b1}} << gran_shift);
    assign zone_size  = XW'(1) << (6'(srbe_pkg::ZONE_SHIFT_BASE) + {4'd0, zone_reg});
    assign end_addr   = {1'b0, addr_reg} + XW'(size_reg);

    assign in_win1 = (mode_reg == srbe_pkg::MODE_WIN1) && (addr_reg[AW-1:0] >= w1s_reg)
                     && (addr_reg[AW-1:0] < w1e_reg);
    assign in_win2 = (mode_reg == srbe_pkg::MODE_WIN2) && (addr_reg[AW-1:0] >= w2s_reg)
                     && (addr_reg[AW-1:0] < w2e_reg);

    assign shifted_addr = addr_reg >> gran_shift;
    assign shifted_size = size_reg >> gran_shift;

    // mask of the covered bits in the current word
    assign end_pos   = EW'(bit_reg) + EW'(count_reg);
    assign full_word = end_pos >= EW'(WB);
    assign lo_mask   = {WB{1'b1}} << bit_reg;
    assign hi_mask   = full_word ? {WB{1'b1}} : ~({WB{1'b1}} << end_pos[BW-1:0]);
    assign bit_mask  = lo_mask & hi_mask;
    assign check_only = (type_reg == srbe_pkg::REQ_CHECK);
    assign wr_data   = (type_reg == srbe_pkg::REQ_SET) ? (rd_data_reg | bit_mask)
                                                       : (rd_data_reg & ~bit_mask);

    always_comb
    begin
        type_next  = type_reg;
        addr_next  = addr_reg;
        size_next  = size_reg;
        word_next  = word_reg;
        bit_next   = bit_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            type_next = req_type;
            addr_next = RW'(req_addr);
            size_next = region_size;
        end
        if (cmd.remap)
        begin
            if (in_win1)
                addr_next = addr_reg - RW'(w1s_reg) + srbe_pkg::REMAP_BASE_ADDR;
            else if (in_win2)
                addr_next = addr_reg - RW'(w2s_reg) + srbe_pkg::REMAP_BASE_ADDR;
        end
        if (cmd.setup)
        begin
            word_next  = shifted_addr[GW-1:BW];
            bit_next   = shifted_addr[BW-1:0];
            count_next = shifted_size[GW-1:0];
        end
        if (cmd.modify)
        begin
            word_next  = word_reg + WW'(1);
            bit_next   = '0;
            count_next = GW'(end_pos - EW'(WB));
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg  <= type_next;
        addr_reg  <= addr_next;
        size_reg  <= size_next;
        word_reg  <= word_next;
        bit_reg   <= bit_next;
        count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr)
            bitmap_mem[clr_cnt_reg] <= '0;
        else if (cmd.modify && !check_only)
            bitmap_mem[word_reg] <= wr_data;
        if (cmd.rd)
            rd_data_reg <= bitmap_mem[word_reg];
    end

    always_comb
    begin
        sts.clr_last   = &clr_cnt_reg;
        sts.misaligned = |(size_reg & gran_mask);
        sts.range_err  = ({1'b0, addr_reg} >= zone_size) || (size_reg == '0)
                         || (end_addr >= zone_size);
        sts.bad_type   = (type_reg != srbe_pkg::REQ_SET) && (type_reg != srbe_pkg::REQ_CLEAR)
                         && (type_reg != srbe_pkg::REQ_CHECK);
        sts.check_fail = check_only && ((rd_data_reg & bit_mask) != bit_mask);
        sts.last_word  = end_pos <= EW'(WB);
    end

endmodule

>>> hdl/srbe_ctrl.sv
module srbe_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output logic            done,
    output logic [2:0]      status,
    output srbe_pkg::cmd_t  cmd,
    input  srbe_pkg::sts_t  sts
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_REMAP  = 6'b000100,
        S_SETUP  = 6'b001000,
        S_READ   = 6'b010000,
        S_MODIFY = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic       done_reg, done_next;
    logic [2:0] status_reg, status_next;

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        cmd         = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_REMAP;
                end
            end
            S_REMAP:
            begin
                cmd.remap  = 1'b1;
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                cmd.setup = 1'b1;
                // size is checked before the range, the type after both
                priority if (sts.misaligned)
                begin
                    done_next   = 1'b1;
                    status_next = srbe_pkg::ST_MISALIGNED;
                    state_next  = S_IDLE;
                end
                else if (sts.range_err)
                begin
                    done_next   = 1'b1;
                    status_next = srbe_pkg::ST_RANGE;
                    state_next  = S_IDLE;
                end
                else if (sts.bad_type)
                begin
                    done_next   = 1'b1;
                    status_next = srbe_pkg::ST_BAD_TYPE;
                    state_next  = S_IDLE;
                end
                else
                    state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_MODIFY;
            end
            S_MODIFY:
            begin
                priority if (sts.check_fail)
                begin
                    done_next   = 1'b1;
                    status_next = srbe_pkg::ST_CHECK_FAIL;
                    state_next  = S_IDLE;
                end
                else if (sts.last_word)
                begin
                    cmd.modify  = 1'b1;
                    done_next   = 1'b1;
                    status_next = srbe_pkg::ST_OK;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.modify = 1'b1;
                    state_next = S_READ;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            done_reg   <= 1'b0;
            status_reg <= srbe_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

endmodule

>>> hdl/srbe_checker.sv
module srbe_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [2:0] status
);

    // a result only closes a transaction that was in flight
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result without a transaction in flight");

    // an accepted transaction keeps the engine busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("engine not busy after accepting a transaction");

    // one result per transaction, never two back to back
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for two cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
                     done |-> (status <= srbe_pkg::ST_BAD_TYPE))
        else $error("status code out of range");

endmodule

bind secure_region_bitmap_engine_core srbe_checker u_srbe_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status)
);

>>> tb/tb_secure_region_bitmap_engine_core.sv
`timescale 1ns / 100ps

module tb_secure_region_bitmap_engine_core;

    import srbe_pkg::*;

    localparam logic [1:0]  REQ_INVALID = 2'd3;
    localparam logic [1:0]  MODE_SPARE  = 2'd3;
    localparam logic [63:0] REMAP_BASE  = 64'(REMAP_BASE_ADDR);
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
    localparam logic [63:0] G0          = 64'h1_0000;
    localparam logic [63:0] G3          = 64'h8_0000;
    localparam logic [63:0] ZONE0       = 64'h1_0000_0000;
    localparam int unsigned STALL_LIMIT = 20000;

    typedef struct {
        logic [2:0]  status;
        int unsigned req_num;
    } status_expect_t;

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic [1:0]            req_type    = '0;
    logic [ADDR_W-1:0]     req_addr    = '0;
    logic [SIZE_W-1:0]     region_size = '0;
    logic                  done;
    logic [2:0]            status;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_W-1:0]      cfg_wdata   = '0;

    // shadow of the register file and of the granule bitmap
    logic [1:0]            cfg_zone = '0;
    logic [1:0]            cfg_mode = '0;
    logic [ADDR_W-1:0]     win1_lo  = '0;
    logic [ADDR_W-1:0]     win1_hi  = '0;
    logic [ADDR_W-1:0]     win2_lo  = '0;
    logic [ADDR_W-1:0]     win2_hi  = '0;
    logic [WORD_BITS-1:0]  granule_map [BITMAP_WORDS];

    status_expect_t        expected_status_q [$];
    int unsigned           req_count      = 0;
    int unsigned           mismatch_count = 0;
    int unsigned           stall_cycles   = 0;
    int unsigned           idle_pct       = 0;
    int unsigned           hot_base       = 0;

    secure_region_bitmap_engine_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .req_addr    (req_addr),
        .region_size (region_size),
        .done        (done),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [ADDR_W-1:0] rand35();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[ADDR_W-1:0];
    endfunction

    // walks the covered granules the way the engine does, updating the shadow bitmap
    function automatic logic [2:0] apply_region_request(input logic [1:0] kind,
                                                         input logic [ADDR_W-1:0] pa,
                                                         input logic [SIZE_W-1:0] len);
        logic [63:0]          gran;
        logic [63:0]          zone_sz;
        logic [63:0]          addr;
        logic [63:0]          idx;
        logic [63:0]          left;
        logic [63:0]          take;
        logic [63:0]          mask;
        logic [WORD_BITS-1:0] cur;
        int unsigned          word;
        int unsigned          bitpos;
        gran    = 64'd1 << (GRAN_SHIFT_BASE + cfg_zone);
        zone_sz = 64'd1 << (ZONE_SHIFT_BASE + cfg_zone);
        if ((len % gran) != 0)
            return ST_MISALIGNED;
        addr = 64'(pa);
        if (cfg_mode == MODE_WIN1 && pa >= win1_lo && pa < win1_hi)
            addr = addr - win1_lo + REMAP_BASE;
        else if (cfg_mode == MODE_WIN2 && pa >= win2_lo && pa < win2_hi)
            addr = addr - win2_lo + REMAP_BASE;
        if (addr >= zone_sz || len == 0 || addr + len >= zone_sz)
            return ST_RANGE;
        if (kind > REQ_CHECK)
            return ST_BAD_TYPE;
        idx    = addr / gran;
        left   = len / gran;
        word   = 32'(idx / WORD_BITS);
        bitpos = 32'(idx % WORD_BITS);
        while (left != 0)
        begin
            take = WORD_BITS - bitpos;
            if (take > left)
                take = left;
            mask = ((64'd1 << take) - 1) << bitpos;
            cur  = (word < BITMAP_WORDS) ? granule_map[word] : '0;
            if (kind == REQ_CHECK)
            begin
                if ((cur & mask[WORD_BITS-1:0]) != mask[WORD_BITS-1:0])
                    return ST_CHECK_FAIL;
            end
            else if (word < BITMAP_WORDS)
            begin
                if (kind == REQ_SET)
                    granule_map[word] = cur | mask[WORD_BITS-1:0];
                else
                    granule_map[word] = cur & ~mask[WORD_BITS-1:0];
            end
            left   = left - take;
            word   = word + 1;
            bitpos = 0;
        end
        return ST_OK;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t ERROR %s", $realtime, msg);
        mismatch_count++;
    endtask

    // start stays high into the next call when no gap is drawn
    task automatic send_request(input logic [1:0] kind, input logic [ADDR_W-1:0] pa,
                                input logic [SIZE_W-1:0] len);
        status_expect_t e;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start       <= 1'b1;
        req_type    <= kind;
        req_addr    <= pa;
        region_size <= len;
        do
            @(posedge clk);
        while (busy);
        e.status  = apply_region_request(kind, pa, len);
        e.req_num = req_count;
        expected_status_q.push_back(e);
        req_count++;
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_ZONE_SELECT: cfg_zone = val[1:0];
            CFG_SHIFT_MODE:  cfg_mode = val[1:0];
            CFG_WIN1_START:  win1_lo  = val;
            CFG_WIN1_END:    win1_hi  = val;
            CFG_WIN2_START:  win2_lo  = val;
            CFG_WIN2_END:    win2_hi  = val;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [1:0] zone, input logic [1:0] mode,
                                input logic [ADDR_W-1:0] w1s, input logic [ADDR_W-1:0] w1e,
                                input logic [ADDR_W-1:0] w2s, input logic [ADDR_W-1:0] w2e);
        wait_all_results();
        write_reg(CFG_ZONE_SELECT, CFG_W'(zone));
        write_reg(CFG_SHIFT_MODE,  CFG_W'(mode));
        write_reg(CFG_WIN1_START,  w1s);
        write_reg(CFG_WIN1_END,    w1e);
        write_reg(CFG_WIN2_START,  w2s);
        write_reg(CFG_WIN2_END,    w2e);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic pick_window(input logic [1:0] zone, output logic [ADDR_W-1:0] lo,
                               output logic [ADDR_W-1:0] hi);
        logic [63:0] gran;
        logic [63:0] v;
        int unsigned k;
        gran = 64'd1 << (GRAN_SHIFT_BASE + zone);
        k    = $urandom_range(0, 4);
        if (k == 0)
        begin
            lo = '0;
            hi = ADDR_MAX;
        end
        else if (k == 1)
        begin
            lo = rand35();
            hi = rand35();
        end
        else
        begin
            v  = $urandom_range(0, 65535) * gran;
            lo = v[ADDR_W-1:0];
            v  = v + $urandom_range(1, 4096) * gran;
            hi = v[ADDR_W-1:0];
        end
    endtask

    // mostly aligned regions around a hot spot so that checks see earlier sets
    task automatic send_random_request();
        logic [1:0]  kind;
        logic [63:0] gran;
        logic [63:0] zone_sz;
        logic [63:0] addr;
        logic [63:0] size;
        logic [63:0] lo;
        int unsigned cnt;
        int unsigned max_cnt;
        int unsigned pick;
        gran    = 64'd1 << (GRAN_SHIFT_BASE + cfg_zone);
        zone_sz = 64'd1 << (ZONE_SHIFT_BASE + cfg_zone);
        max_cnt = 32'(64'hFFFF_FFFF / gran);
        pick    = $urandom_range(0, 99);
        if (pick < 12)
        begin
            kind = 2'($urandom);
            addr = 64'(rand35());
            size = $urandom;
        end
        else
        begin
            kind = 2'($urandom_range(0, 2));
            if ($urandom_range(0, 24) == 0)
                kind = REQ_INVALID;
            pick = $urandom_range(0, 199);
            if (pick == 0)
                cnt = $urandom_range(1, max_cnt);
            else if (pick < 24)
                cnt = $urandom_range(33, 300);
            else
                cnt = $urandom_range(1, 40);
            size = cnt * gran;
            pick = $urandom_range(0, 39);
            if (pick == 0)
                size = 0;
            else if (pick < 3)
                size = size + $urandom_range(1, 32'(gran - 1));
            pick = $urandom_range(0, 29);
            if (pick < 2)
                addr = zone_sz - size - $urandom_range(0, 2) * gran;
            else if (pick < 9 && (cfg_mode == MODE_WIN1 || cfg_mode == MODE_WIN2))
            begin
                lo   = (cfg_mode == MODE_WIN1) ? 64'(win1_lo) : 64'(win2_lo);
                addr = lo + $urandom_range(0, 600) * gran;
            end
            else
                addr = (hot_base + $urandom_range(0, 127)) * gran;
            if ($urandom_range(0, 9) == 0)
                addr = addr + $urandom_range(0, 32'(gran - 1));
        end
        send_request(kind, addr[ADDR_W-1:0], size[SIZE_W-1:0]);
    endtask

    task automatic test_cleared_after_reset();
        send_request(REQ_CHECK, '0, G0);
        send_request(REQ_CHECK, ZONE0 - 2 * G0, G0);
    endtask

    task automatic test_set_clear_check();
        send_request(REQ_SET,   '0, G0);
        send_request(REQ_CHECK, '0, G0);
        send_request(REQ_CLEAR, '0, G0);
        send_request(REQ_CHECK, '0, G0);
        // crosses a word boundary, then checked from an unaligned address
        send_request(REQ_SET,   30 * G0, 4 * G0);
        send_request(REQ_CHECK, 31 * G0 + 64'h123, 2 * G0);
    endtask

    task automatic test_status_precedence();
        send_request(REQ_SET,     '0, 32'd1);
        send_request(REQ_SET,     '0, 32'hFFFF_FFFF);
        send_request(REQ_SET,     '0, '0);
        send_request(REQ_INVALID, '0, 32'd1);
        send_request(REQ_INVALID, '0, '0);
        send_request(REQ_INVALID, '0, G0);
        send_request(REQ_CHECK,   ADDR_MAX, G0);
    endtask

    task automatic test_zone_end();
        send_request(REQ_SET, ZONE0 - G0, G0);
        send_request(REQ_SET, ZONE0 - 2 * G0, G0);
    endtask

    task automatic test_largest_region();
        send_request(REQ_SET,   '0, 32'hFFFF_0000);
        send_request(REQ_CHECK, '0, 32'hFFFF_0000);
        send_request(REQ_CLEAR, '0, 32'hFFFF_0000);
        program_regs(2'd3, MODE_NONE, '0, '0, '0, '0);
        send_request(REQ_CHECK, '0, 32'hFFF8_0000);
    endtask

    task automatic test_remap_windows();
        program_regs(2'd3, MODE_WIN1, 35'h0_4000_0000, 35'h0_5000_0000,
                     35'h6_0000_0000, ADDR_MAX);
        send_request(REQ_SET,   35'h0_4000_0000, G3);
        send_request(REQ_CHECK, 35'h0_E000_0000, G3);
        program_regs(2'd3, MODE_WIN2, win1_lo, win1_hi, win2_lo, win2_hi);
        send_request(REQ_CHECK, 35'h6_0000_0000, G3);
        program_regs(2'd3, MODE_SPARE, win1_lo, win1_hi, win2_lo, win2_hi);
        send_request(REQ_CHECK, 35'h0_4000_0000, G3);
        // a window over the whole space adds the remap base, pushing this address past a small zone
        program_regs(2'd0, MODE_WIN1, '0, ADDR_MAX, win2_lo, win2_hi);
        send_request(REQ_SET, 35'h0_2000_0000, G0);
    endtask

    task automatic test_random_settings();
        logic [1:0]        zone;
        logic [1:0]        mode;
        logic [ADDR_W-1:0] w1s;
        logic [ADDR_W-1:0] w1e;
        logic [ADDR_W-1:0] w2s;
        logic [ADDR_W-1:0] w2e;
        for (int p = 0; p < 8; p++)
        begin
            zone = (p == 0) ? 2'd0 : (p == 1) ? 2'd3 : 2'($urandom_range(0, 3));
            mode = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
            pick_window(zone, w1s, w1e);
            pick_window(zone, w2s, w2e);
            idle_pct = 0;
            program_regs(zone, mode, w1s, w1e, w2s, w2e);
            hot_base = $urandom_range(0, 65535 - 128);
            idle_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 50);
            repeat (150) send_random_request();
        end
    endtask

    task automatic test_pause_until_drained();
        idle_pct = 20;
        repeat (5)
        begin
            send_random_request();
            send_random_request();
            wait_all_results();
        end
    endtask

    task automatic test_unthrottled_tail();
        logic [ADDR_W-1:0] w1s;
        logic [ADDR_W-1:0] w1e;
        logic [ADDR_W-1:0] w2s;
        logic [ADDR_W-1:0] w2e;
        logic [1:0]        zone;
        zone = 2'($urandom_range(0, 3));
        pick_window(zone, w1s, w1e);
        pick_window(zone, w2s, w2e);
        idle_pct = 0;
        program_regs(zone, 2'($urandom_range(0, 3)), w1s, w1e, w2s, w2e);
        hot_base = $urandom_range(0, 65535 - 128);
        repeat (200) send_random_request();
    endtask

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    always @(posedge clk)
    begin : check_result
        status_expect_t head;
        if (rst_n && done)
        begin
            if (expected_status_q.size() == 0)
                flag_mismatch($sformatf("status %0d with no request outstanding", status));
            else
            begin
                head = expected_status_q.pop_front();
                if (status !== head.status)
                    flag_mismatch($sformatf("request %0d: status %0d, predicted %0d",
                                            head.req_num, status, head.status));
            end
        end
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        foreach (granule_map[i])
            granule_map[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_cleared_after_reset();
        test_set_clear_check();
        test_status_precedence();
        test_zone_end();
        test_largest_region();
        test_remap_windows();
        test_random_settings();
        test_pause_until_drained();
        test_unthrottled_tail();
        wait_all_results();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
hdl/srbe_pkg.sv
hdl/srbe_datapath.sv
hdl/srbe_ctrl.sv
hdl/secure_region_bitmap_engine_core.sv
hdl/srbe_checker.sv
tb/tb_secure_region_bitmap_engine_core.sv
